>>> rtl/core/gkr_pkg.sv
// ============================================================================
// Grouped key ring registry package
// Shared constants, codes, controller states and command/status records.
// ============================================================================
`default_nettype none

package gkr_pkg;

  localparam int KEY_SLOTS = 256;
  localparam int GROUPS    = 8;
  localparam int SLOT_AW   = $clog2(KEY_SLOTS);     // slot / key index width
  localparam int MARK_W    = SLOT_AW + 1;           // key or slot with empty mark
  localparam int GRP_W     = $clog2(GROUPS);
  localparam int GMARK_W   = GRP_W + 1;             // group with no-group mark
  localparam int BND_AW    = GRP_W + 1;             // bound table index
  localparam int LOOP_W    = GRP_W + 1;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_READ   = 2'd2,
    FN_CLEAR  = 2'd3
  } fn_t;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_LOOK,
    ST_CHK,
    ST_APL,
    ST_SHR,
    ST_SHW,
    ST_RMW,
    ST_RDI,
    ST_RDQ,
    ST_CLR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic ld;          // capture transaction fields
    logic clr_step;    // one wipe sweep step
    logic add_head;    // grow target group by one slot
    logic add_place;   // place new key, capture displaced content
    logic sh_read;     // shift next neighbor bounds, fetch slot
    logic sh_write;    // store carried key in shifted slot
    logic rm_head;     // pull bound in, fetch filler key
    logic rm_write;    // fill the hole
    logic rd_issue;    // fetch slot for read
    logic rd_take;     // capture read result
    logic set_err;     // refuse transaction
  } cmd_t;

  typedef struct packed {
    fn_t  func;
    logic absent;      // key carries no group mark
    logic full;        // every slot taken
    logic more;        // another neighbor must shift
    logic sweep_last;  // wipe sweep at its final slot
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/gkr_ram.sv
// ============================================================================
// Generic single-write RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module gkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/gkr_ctrl.sv
// ============================================================================
// Registry controller
// Sequences lookups, group shifts, hole fills, reads and wipe sweeps.
// ============================================================================
`default_nettype none

module gkr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire gkr_pkg::stat_t st,
  output gkr_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               done
);
  import gkr_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_WIPE: begin
        cmd.clr_step = 1'b1;
        if (st.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.ld = 1'b1;
          unique case (st.func)
            FN_ADD, FN_REMOVE: state_next = ST_LOOK;
            FN_READ:           state_next = ST_RDI;
            FN_CLEAR:          state_next = ST_CLR;
            default:           state_next = ST_CLR;
          endcase
        end
      end
      ST_LOOK: state_next = ST_CHK;
      ST_CHK: begin
        if (st.func == FN_ADD) begin
          if (!st.absent || st.full) begin
            cmd.set_err = 1'b1;
            state_next  = ST_FIN;
          end else begin
            cmd.add_head = 1'b1;
            state_next   = ST_APL;
          end
        end else begin
          if (st.absent) begin
            cmd.set_err = 1'b1;
            state_next  = ST_FIN;
          end else begin
            cmd.rm_head = 1'b1;
            state_next  = ST_RMW;
          end
        end
      end
      ST_APL: begin
        cmd.add_place = 1'b1;
        state_next    = st.more ? ST_SHR : ST_FIN;
      end
      ST_SHR: begin
        cmd.sh_read = 1'b1;
        state_next  = ST_SHW;
      end
      ST_SHW: begin
        cmd.sh_write = 1'b1;
        state_next   = st.more ? ST_SHR : ST_FIN;
      end
      ST_RMW: begin
        cmd.rm_write = 1'b1;
        state_next   = ST_FIN;
      end
      ST_RDI: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RDQ;
      end
      ST_RDQ: begin
        cmd.rd_take = 1'b1;
        state_next  = ST_FIN;
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.sweep_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_WIPE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/gkr_dp.sv
// ============================================================================
// Registry datapath
// Group bounds and counts, slot/key memories and the shift carry registers.
// ============================================================================
`default_nettype none

module gkr_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gkr_pkg::cmd_t                 cmd,
  input  wire logic [1:0]                    func,
  input  wire logic [gkr_pkg::SLOT_AW-1:0]   key,
  input  wire logic [gkr_pkg::GRP_W-1:0]     group,
  input  wire logic [gkr_pkg::SLOT_AW-1:0]   position,
  output gkr_pkg::stat_t                     st,
  output logic      [gkr_pkg::MARK_W-1:0]    read_key,
  output logic      [gkr_pkg::MARK_W-1:0]    total_count,
  output logic                               error
);
  import gkr_pkg::*;

  localparam logic [SLOT_AW-1:0] START0 = SLOT_AW'(KEY_SLOTS / 2);
  localparam logic [SLOT_AW-1:0] END0   = SLOT_AW'(KEY_SLOTS / 2 - 1);
  localparam logic [MARK_W-1:0]  EMPTY  = MARK_W'(KEY_SLOTS);
  localparam logic [GMARK_W-1:0] NOGRP  = GMARK_W'(GROUPS);

  fn_t                func_r;
  logic [SLOT_AW-1:0] key_r, pos_r;
  logic [GRP_W-1:0]   grp_r, g_r;
  logic               up_r, has_r;
  logic [SLOT_AW-1:0] idx_r, last_end_r;
  logic [MARK_W-1:0]  limbo_r, hole_r, rdk_r, total;
  logic [LOOP_W-1:0]  i_r;
  logic               err_r;
  logic [SLOT_AW-1:0] sweep;
  logic [SLOT_AW-1:0] bounds [2*GROUPS];
  logic [MARK_W-1:0]  counts [GROUPS];

  logic [MARK_W-1:0]  slot_q, ks_q;
  logic [GMARK_W-1:0] kg_q;

  function automatic logic [SLOT_AW-1:0] step(input logic [SLOT_AW-1:0] x, input logic up);
    return up ? x + 1'b1 : x - 1'b1;
  endfunction

  // free space around the addressed group
  logic [GRP_W-1:0]   g_sel;
  logic [SLOT_AW-1:0] sp_after, sp_before;
  logic               up_add, up_rm;
  logic [BND_AW-1:0]  b_add, b_rm;
  logic [SLOT_AW-1:0] idx_h, from;

  assign g_sel     = cmd.rm_head ? kg_q[GRP_W-1:0] : grp_r;
  assign sp_after  = bounds[{g_sel + 1'b1, 1'b0}] - bounds[{g_sel, 1'b1}];
  assign sp_before = bounds[{g_sel, 1'b0}] - bounds[{g_sel - 1'b1, 1'b1}];
  assign up_add    = sp_after >= sp_before;
  assign up_rm     = sp_after <= sp_before;
  assign b_add     = {grp_r, up_add};
  assign b_rm      = {g_sel, up_rm};
  assign idx_h     = step(bounds[b_add], up_add);
  assign from      = bounds[b_rm];

  // neighbor shift values
  logic [GRP_W-1:0]   g_nx;
  logic [SLOT_AW-1:0] far;
  logic [MARK_W-1:0]  place;
  logic               meets;
  logic [LOOP_W-1:0]  i_cmp;

  assign g_nx  = up_r ? g_r + 1'b1 : g_r - 1'b1;
  assign far   = bounds[{g_nx, up_r}];
  assign place = has_r ? limbo_r : slot_q;
  assign meets = up_r ? (bounds[{g_r, 1'b1}] == bounds[{g_r + 1'b1, 1'b0}])
                      : (bounds[{g_r, 1'b0}] == bounds[{g_r - 1'b1, 1'b1}]);
  assign i_cmp = cmd.sh_write ? i_r + 1'b1 : i_r;

  // status to controller
  assign st.func       = cmd.ld ? fn_t'(func) : func_r;
  assign st.absent     = kg_q >= NOGRP;
  assign st.full       = total >= EMPTY;
  assign st.more       = meets && (i_cmp < LOOP_W'(GROUPS));
  assign st.sweep_last = sweep == '1;

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      total <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        counts[g]       <= '0;
        bounds[2*g]     <= START0;
        bounds[2*g + 1] <= END0;
      end
    end else begin
      if (cmd.clr_step) begin
        sweep <= sweep + 1'b1;
        total <= '0;
        for (int g = 0; g < GROUPS; g++) begin
          counts[g]       <= '0;
          bounds[2*g]     <= START0;
          bounds[2*g + 1] <= END0;
        end
      end
      if (cmd.add_head) begin
        counts[grp_r] <= counts[grp_r] + 1'b1;
        total         <= total + 1'b1;
        bounds[b_add] <= idx_h;
      end
      if (cmd.sh_read) begin
        bounds[{g_nx, 1'b0}] <= step(bounds[{g_nx, 1'b0}], up_r);
        bounds[{g_nx, 1'b1}] <= step(bounds[{g_nx, 1'b1}], up_r);
      end
      if (cmd.rm_head) begin
        if (counts[g_sel] != '0) begin
          counts[g_sel] <= counts[g_sel] - 1'b1;
          total         <= total - 1'b1;
        end
        bounds[b_rm] <= step(from, !up_rm);
      end
    end
  end

  // transaction payload and carry registers
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      func_r <= fn_t'(func);
      key_r  <= key;
      grp_r  <= group;
      pos_r  <= position;
      err_r  <= 1'b0;
      rdk_r  <= '0;
    end
    if (cmd.set_err) err_r <= 1'b1;
    if (cmd.add_head) begin
      idx_r      <= idx_h;
      last_end_r <= bounds[b_add];
      up_r       <= up_add;
      g_r        <= grp_r;
      i_r        <= LOOP_W'(1);
    end
    if (cmd.add_place) limbo_r <= slot_q;
    if (cmd.sh_read) begin
      g_r        <= g_nx;
      last_end_r <= far;
      has_r      <= far != last_end_r;
      idx_r      <= step(far, up_r);
    end
    if (cmd.sh_write) begin
      if (has_r) limbo_r <= slot_q;
      i_r <= i_r + 1'b1;
    end
    if (cmd.rm_head) hole_r <= ks_q;
    if (cmd.rd_take) rdk_r <= slot_q;
  end

  // slot memory ports
  logic               s_we, ks_we, kg_we;
  logic [SLOT_AW-1:0] s_wa, s_ra, ks_wa, kg_wa;
  logic [MARK_W-1:0]  s_wd, ks_wd;
  logic [GMARK_W-1:0] kg_wd;

  always_comb begin
    s_we  = 1'b0;  s_wa  = sweep; s_wd  = EMPTY;
    ks_we = 1'b0;  ks_wa = sweep; ks_wd = EMPTY;
    kg_we = 1'b0;  kg_wa = sweep; kg_wd = NOGRP;
    s_ra  = sweep;
    if (cmd.clr_step) begin
      s_we = 1'b1; ks_we = 1'b1; kg_we = 1'b1;
    end
    if (cmd.add_head) begin
      kg_we = 1'b1; kg_wa = key_r; kg_wd = {1'b0, grp_r};
      ks_we = 1'b1; ks_wa = key_r; ks_wd = {1'b0, idx_h};
      s_ra  = idx_h;
    end
    if (cmd.add_place) begin
      s_we = 1'b1; s_wa = idx_r; s_wd = {1'b0, key_r};
    end
    if (cmd.sh_read) s_ra = step(far, up_r);
    if (cmd.sh_write) begin
      s_we  = 1'b1;         s_wa  = idx_r;              s_wd  = place;
      ks_we = !place[SLOT_AW]; ks_wa = place[SLOT_AW-1:0]; ks_wd = {1'b0, idx_r};
    end
    if (cmd.rm_head) begin
      kg_we = 1'b1; kg_wa = key_r; kg_wd = NOGRP;
      s_ra  = from;
    end
    if (cmd.rm_write) begin
      s_we  = !hole_r[SLOT_AW];                 s_wa  = hole_r[SLOT_AW-1:0]; s_wd  = slot_q;
      ks_we = !hole_r[SLOT_AW] && !slot_q[SLOT_AW];
      ks_wa = slot_q[SLOT_AW-1:0];              ks_wd = hole_r;
    end
    // fetch the slot at group start plus offset
    if (cmd.rd_issue) s_ra = bounds[{grp_r, 1'b0}] + pos_r;
  end

  gkr_ram #(.WIDTH(MARK_W), .DEPTH(KEY_SLOTS)) u_slot_keys (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(slot_q)
  );

  gkr_ram #(.WIDTH(MARK_W), .DEPTH(KEY_SLOTS)) u_key_slot (
    .clk(clk), .we(ks_we), .waddr(ks_wa), .wdata(ks_wd), .raddr(key_r), .rdata(ks_q)
  );

  gkr_ram #(.WIDTH(GMARK_W), .DEPTH(KEY_SLOTS)) u_key_group (
    .clk(clk), .we(kg_we), .waddr(kg_wa), .wdata(kg_wd), .raddr(key_r), .rdata(kg_q)
  );

  assign read_key    = rdk_r;
  assign total_count = total;
  assign error       = err_r;

endmodule

`default_nettype wire

>>> rtl/core/grouped_key_ring_registry.sv
// ============================================================================
// Grouped key ring registry
// Done follows accept through these states: read RDI, RDQ; remove LOOK,
// CHK, RMW; refused add/remove LOOK, CHK; add LOOK, CHK, APL, then SHR and
// SHW per shifted neighbor group (up to 7 groups); clear a CLR sweep over
// every slot. One transaction at a time; the next is accepted in the cycle
// after done. Reset runs a wipe of the slot and key memories with busy high.
// ============================================================================
`default_nettype none

module grouped_key_ring_registry (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    func,
  input  wire logic [gkr_pkg::SLOT_AW-1:0]   key,
  input  wire logic [gkr_pkg::GRP_W-1:0]     group,
  input  wire logic [gkr_pkg::SLOT_AW-1:0]   position,
  output logic                               done,
  output logic      [gkr_pkg::MARK_W-1:0]    read_key,
  output logic      [gkr_pkg::MARK_W-1:0]    total_count,
  output logic                               error
);
  import gkr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequence control
  gkr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .cmd(cmd), .busy(busy), .done(done)
  );

  // storage and arithmetic
  gkr_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .func(func), .key(key), .group(group),
    .position(position), .st(st), .read_key(read_key), .total_count(total_count),
    .error(error)
  );

endmodule

`default_nettype wire

>>> sim/tb_grouped_key_ring_registry.sv
// ============================================================================
// Grouped key ring registry testbench
// Drives add, remove, read and clear transactions through the start/busy
// handshake with random idle bursts. A ring model predicts every result, and
// each done strobe is compared field by field with the oldest prediction.
// Covers directed corner cases, a fill up to a full store, and random traffic.
// ============================================================================
`default_nettype none

module tb_grouped_key_ring_registry;
  import gkr_pkg::*;

  typedef struct {
    logic [MARK_W-1:0] read_key;
    logic [MARK_W-1:0] total_count;
    logic              error;
  } outcome_t;

  // Ring model of the registry plus the queue of predicted outcomes
  class ring_scoreboard;
    logic [SLOT_AW-1:0] bnd[2*GROUPS];
    int                 cnt[GROUPS];
    logic [MARK_W-1:0]  slot_key[KEY_SLOTS];
    logic [MARK_W-1:0]  key_pos[KEY_SLOTS];
    int                 key_grp[KEY_SLOTS];
    outcome_t           pending_q[$];
    int                 failures;
    int                 checked;
    int                 refusals;

    function void wipe();
      for (int g = 0; g < GROUPS; g++) begin
        cnt[g]       = 0;
        bnd[2*g]     = SLOT_AW'(KEY_SLOTS / 2);
        bnd[2*g + 1] = SLOT_AW'(KEY_SLOTS / 2 - 1);
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slot_key[i] = MARK_W'(KEY_SLOTS);
        key_pos[i]  = MARK_W'(KEY_SLOTS);
        key_grp[i]  = GROUPS;
      end
    endfunction

    function int total();
      int s;
      s = 0;
      for (int g = 0; g < GROUPS; g++) s += cnt[g];
      return s;
    endfunction

    function logic [SLOT_AW-1:0] nudge(logic [SLOT_AW-1:0] x, bit up);
      return up ? x + 1'b1 : x - 1'b1;
    endfunction

    function int room_before(int g);
      logic [SLOT_AW-1:0] d;
      d = bnd[2*g] - bnd[(2*g + 2*GROUPS - 1) % (2*GROUPS)];
      return int'(d);
    endfunction

    function int room_after(int g);
      logic [SLOT_AW-1:0] d;
      d = bnd[(2*g + 2) % (2*GROUPS)] - bnd[2*g + 1];
      return int'(d);
    endfunction

    function bit touches(int g, bit up);
      int b;
      int nb;
      b  = 2*g + (up ? 1 : 0);
      nb = up ? (b + 1) % (2*GROUPS) : (b + 2*GROUPS - 1) % (2*GROUPS);
      return bnd[b] == bnd[nb];
    endfunction

    // Grow the group by one slot and push colliding neighbors along the ring
    function void insert_key(int k, int g);
      bit                 up;
      bit                 crowded;
      bit                 has_keys;
      int                 b;
      logic [SLOT_AW-1:0] last_end;
      logic [SLOT_AW-1:0] far_bnd;
      logic [SLOT_AW-1:0] idx;
      logic [MARK_W-1:0]  carried;
      logic [MARK_W-1:0]  prior;
      logic [MARK_W-1:0]  place;
      cnt[g]++;
      up       = room_after(g) >= room_before(g);
      b        = 2*g + (up ? 1 : 0);
      last_end = bnd[b];
      idx      = nudge(last_end, up);
      key_grp[k]    = g;
      key_pos[k]    = {1'b0, idx};
      carried       = slot_key[idx];
      slot_key[idx] = MARK_W'(k);
      bnd[b]        = idx;
      crowded = touches(g, up);
      for (int i = 1; i < GROUPS && crowded; i++) begin
        g        = up ? (g + 1) % GROUPS : (g + GROUPS - 1) % GROUPS;
        far_bnd  = bnd[2*g + (up ? 1 : 0)];
        has_keys = far_bnd != last_end;
        last_end = far_bnd;
        bnd[2*g]     = nudge(bnd[2*g], up);
        bnd[2*g + 1] = nudge(bnd[2*g + 1], up);
        idx   = nudge(far_bnd, up);
        prior = slot_key[idx];
        place = has_keys ? carried : prior;
        slot_key[idx] = place;
        if (place < KEY_SLOTS) key_pos[place] = {1'b0, idx};
        if (has_keys) carried = prior;
        crowded = touches(g, up);
      end
    endfunction

    // Fill the hole from the bound on the tighter side (end bound on a tie) and pull that bound in
    function void drop_key(int k);
      int                 g;
      bit                 up;
      int                 b;
      logic [MARK_W-1:0]  hole;
      logic [SLOT_AW-1:0] src;
      logic [MARK_W-1:0]  moved;
      hole       = key_pos[k];
      g          = key_grp[k];
      key_grp[k] = GROUPS;
      if (cnt[g] > 0) cnt[g]--;
      up  = room_after(g) <= room_before(g);
      b   = 2*g + (up ? 1 : 0);
      src = bnd[b];
      if (hole < KEY_SLOTS) begin
        moved = slot_key[src];
        slot_key[hole[SLOT_AW-1:0]] = moved;
        if (moved < KEY_SLOTS) key_pos[moved] = hole;
      end
      bnd[b] = nudge(src, !up);
    endfunction

    // Note an accepted transaction and queue its predicted outcome
    function void note(fn_t f, int k, int g, int p);
      outcome_t o;
      logic [SLOT_AW-1:0] s;
      o.read_key = '0;
      o.error    = 1'b0;
      case (f)
        FN_ADD: begin
          if (total() >= KEY_SLOTS || key_grp[k] < GROUPS) o.error = 1'b1;
          else insert_key(k, g);
        end
        FN_REMOVE: begin
          if (key_grp[k] >= GROUPS) o.error = 1'b1;
          else drop_key(k);
        end
        FN_READ: begin
          s = bnd[2*g] + p[SLOT_AW-1:0];
          o.read_key = slot_key[s];
        end
        default: wipe();
      endcase
      if (o.error) refusals++;
      o.total_count = MARK_W'(total());
      pending_q.push_back(o);
    endfunction

    function void check(logic [MARK_W-1:0] rk, logic [MARK_W-1:0] tc, logic er);
      outcome_t o;
      checked++;
      if (pending_q.size() == 0) begin
        failures++;
        $display("%0t: unexpected result read_key=%0d total_count=%0d error=%0d",
                 $time, rk, tc, er);
        return;
      end
      o = pending_q.pop_front();
      if (rk !== o.read_key) begin
        failures++;
        $display("%0t: read_key expected %0d actual %0d", $time, o.read_key, rk);
      end
      if (tc !== o.total_count) begin
        failures++;
        $display("%0t: total_count expected %0d actual %0d", $time, o.total_count, tc);
      end
      if (er !== o.error) begin
        failures++;
        $display("%0t: error expected %0d actual %0d", $time, o.error, er);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 4000;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic [1:0]         func = FN_READ;
  logic [SLOT_AW-1:0] key = '0;
  logic [GRP_W-1:0]   group = '0;
  logic [SLOT_AW-1:0] position = '0;
  logic               busy;
  logic               done;
  logic [MARK_W-1:0]  read_key;
  logic [MARK_W-1:0]  total_count;
  logic               error;

  ring_scoreboard sb;
  int  fn_seen[4];
  int  stall_cycles = 0;
  bit  quiet = 0;

  grouped_key_ring_registry dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .key(key), .group(group), .position(position),
    .done(done), .read_key(read_key), .total_count(total_count), .error(error)
  );

  always #4 clk = ~clk;

  // Check every result strobe and watch for a stalled handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check(read_key, total_count, error);
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Issue one transaction; caller is at a rising edge
  task automatic send(fn_t f, int k, int g, int p);
    start    <= 1'b1;
    func     <= f;
    key      <= SLOT_AW'(k);
    group    <= GRP_W'(g);
    position <= SLOT_AW'(p);
    do @(posedge clk); while (busy);
    sb.note(f, k, g, p);
    fn_seen[f]++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Hold off until every predicted result has arrived
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic int present_key();
    int k;
    k = $urandom_range(0, KEY_SLOTS - 1);
    if (sb.total() == 0) return k;
    while (sb.key_grp[k] >= GROUPS) k = (k + 1) % KEY_SLOTS;
    return k;
  endfunction

  function automatic int read_pos(int g);
    if (sb.cnt[g] > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, sb.cnt[g] - 1);
    return $urandom_range(0, KEY_SLOTS - 1);
  endfunction

  task automatic random_item();
    int r;
    int g;
    r = $urandom_range(0, 99);
    g = $urandom_range(0, GROUPS - 1);
    if (r < 45) send(FN_ADD, $urandom_range(0, KEY_SLOTS - 1), g, $urandom_range(0, 255));
    else if (r < 70) send(FN_REMOVE, (r < 66) ? present_key() : $urandom_range(0, 255), g,
                          $urandom_range(0, 255));
    else if (r < 99) send(FN_READ, $urandom_range(0, 255), g, read_pos(g));
    else send(FN_CLEAR, $urandom_range(0, 255), g, $urandom_range(0, 255));
  endtask

  initial begin
    int order[KEY_SLOTS];
    int j;
    int t;
    sb = new;
    sb.wipe();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty reads, extremes, duplicate add, absent remove, clear
    send(FN_READ, 0, 0, 0);
    send(FN_READ, 255, 7, 255);
    send(FN_ADD, 0, 0, 0);
    send(FN_ADD, 255, 7, 255);
    send(FN_ADD, 0, 3, 0);
    send(FN_REMOVE, 17, 0, 0);
    for (int g = 1; g < 7; g++) send(FN_ADD, 16 * g + 1, g, 0);
    send(FN_ADD, 170, 0, 0);
    send(FN_ADD, 85, 7, 0);
    send(FN_READ, 0, 0, 0);
    send(FN_READ, 0, 0, 255);
    send(FN_READ, 0, 7, 1);
    send(FN_REMOVE, 255, 7, 0);
    send(FN_REMOVE, 0, 0, 0);
    send(FN_REMOVE, 0, 0, 0);
    send(FN_CLEAR, 0, 0, 0);
    send(FN_READ, 0, 7, 255);
    drain();

    // Fill every slot in random order and groups, then refuse one more add
    for (int i = 0; i < KEY_SLOTS; i++) order[i] = i;
    for (int i = KEY_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      send(FN_ADD, order[i], ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) : 2, 0);
      if (i % 32 == 31) send(FN_READ, 0, $urandom_range(0, 7), $urandom_range(0, 255));
    end
    drain();
    send(FN_ADD, 0, 5, 0);
    for (int i = 0; i < 20; i++) send(FN_REMOVE, present_key(), 0, 0);
    for (int i = 0; i < 8; i++) send(FN_READ, 0, i, read_pos(i));
    send(FN_CLEAR, 0, 0, 0);

    // Random traffic, with a drain midway and a quiet tail with no idle gaps
    for (int i = 0; i < 420; i++) begin
      if (i == 200) drain();
      if (i == 340) quiet = 1;
      random_item();
    end
    drain();
    repeat (40) @(posedge clk);

    $display("Ran %0d adds, %0d removes, %0d reads, %0d clears; %0d refused.",
             fn_seen[FN_ADD], fn_seen[FN_REMOVE], fn_seen[FN_READ], fn_seen[FN_CLEAR],
             sb.refusals);
    $display("Checked %0d results, store filled to capacity once.", sb.checked);
    if (sb.failures == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
